@@ hw/rtl/ole_pkg.sv @@
package ole_pkg;

  localparam int unsigned DefCapacity = 16;
  localparam int unsigned ValueW      = 32;
  localparam int unsigned PositionW   = 5;
  localparam int unsigned LengthW     = 5;
  localparam int unsigned StatusW     = 3;

  // command codes
  localparam logic [1:0] CMD_APPEND = 2'd0;
  localparam logic [1:0] CMD_INSERT = 2'd1;
  localparam logic [1:0] CMD_DELETE = 2'd2;
  localparam logic [1:0] CMD_DUMP   = 2'd3;

  // status codes
  localparam logic [StatusW-1:0] ST_OK        = 3'd0;
  localparam logic [StatusW-1:0] ST_EMPTY     = 3'd1;
  localparam logic [StatusW-1:0] ST_NOT_FOUND = 3'd2;
  localparam logic [StatusW-1:0] ST_BAD_POS   = 3'd3;
  localparam logic [StatusW-1:0] ST_FULL      = 3'd4;

  // per-cycle operation broadcast to every cell
  typedef enum logic [2:0] {
    OP_HOLD,
    OP_INSERT,
    OP_MATCH,
    OP_REMOVE,
    OP_ROTATE
  } ole_op_e;

  typedef struct packed {
    ole_op_e             op;
    logic [ValueW-1:0]   value;
  } ole_ctrl_t;

endpackage

@@ hw/rtl/ordered_list_engine.sv @@
// Ordered list engine: keeps up to CAPACITY signed 32-bit entries in a row of
// cells, head in cell 0, and executes one command per input beat.
// Slave channel s_axis: command, position, value. Master channel m_axis: one
// result beat per command (status, length, tlast = 1), or for a dump of a
// non-empty list one beat per entry, head first, tlast on the final entry.
// From input accept to result valid:
//   append / insert: all cells shift in parallel; result valid in the next cycle
//   delete:          cells compare and register a hit bit, then
//                    the first-hit chain selects which cells shift up;
//                    on an empty list the result is valid in the next cycle
//   dump:            first entry in the next cycle, then one entry per cycle
//                    while m_axis_tready_i is high (the chain rotates by one cell per beat)
// One command is in flight at a time; the next command beat is taken in the
// cycle its predecessor's result is taken (IDLE, or the single result beat
// leaving), so append/insert run at 1 command per cycle while m_axis_tready_i
// is high, and delete takes no command while in S_DEL; a dump of N entries
// streams N beats; the next command is taken in the cycle after its last beat.
// Reset (rst_ni low, asynchronous) empties the list; entries are not cleared.
// A stalled receiver holds the result beat steady and stops the block from
// taking new commands until that beat leaves.
module ordered_list_engine import ole_pkg::*; #(
  parameter int unsigned CAPACITY = DefCapacity
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // [1:0] command, [6:2] position, [38:7] value, [39] zero fill
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // [2:0] status, [34:3] entry_value, [39:35] length
  output logic [39:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o
);

  localparam int unsigned CountW = $clog2(CAPACITY + 1);
  localparam int unsigned PosCmpW = (CountW > PositionW) ? CountW : PositionW;
  localparam logic [CountW-1:0] CountFull = CountW'(CAPACITY);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RESP = 2'd1;
  localparam logic [1:0] S_DEL  = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [1:0]          state_q, state_d;
  logic [CountW-1:0]   count_q, count_d;
  logic [CountW-1:0]   idx_q, idx_d;
  logic [StatusW-1:0]  st_q, st_d;

  logic [1:0]          cmd;
  logic [PositionW-1:0] position;
  logic [ValueW-1:0]   value;
  logic                in_fire, out_fire;
  logic [PosCmpW-1:0]  pos_ext;
  logic                dump_last;

  ole_ctrl_t           ctrl;
  logic [CountW-1:0]   cell_pos;
  logic [ValueW-1:0]   entry [CAPACITY];
  logic                found [CAPACITY+1];

  assign cmd      = s_axis_tdata_i[1:0];
  assign position = s_axis_tdata_i[6:2];
  assign value    = s_axis_tdata_i[38:7];
  assign pos_ext  = PosCmpW'(position);

  assign in_fire  = s_axis_tvalid_i && s_axis_tready_o;
  assign out_fire = m_axis_tvalid_o && m_axis_tready_i;
  assign dump_last = (idx_q + CountW'(1)) == count_q;

  // ---- cell row ----
  assign found[0] = 1'b0;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [ValueW-1:0] left_v, right_v;
    if (g == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_mid
      assign left_v = entry[g-1];
    end
    if (g == CAPACITY - 1) begin : g_tail
      assign right_v = entry[g];
    end else begin : g_body
      assign right_v = entry[g+1];
    end
    ole_cell #(
      .CountW  (CountW),
      .CellIdx (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (cell_pos),
      .count_i (count_q),
      .left_i  (left_v),
      .right_i (right_v),
      .head_i  (entry[0]),
      .found_i (found[g]),
      .entry_o (entry[g]),
      .found_o (found[g+1])
    );
  end

  // ---- sequencer ----
  always_comb begin
    state_d    = state_q;
    count_d    = count_q;
    idx_d      = idx_q;
    st_d       = st_q;
    ctrl.op    = OP_HOLD;
    ctrl.value = value;
    cell_pos   = count_q;

    unique case (state_q)
      S_RESP: begin
        if (out_fire) begin
          state_d = S_IDLE;
        end
      end
      S_DEL: begin
        // hit bits are registered; the chain picks the first hit
        ctrl.op = OP_REMOVE;
        if (found[CAPACITY]) begin
          count_d = count_q - CountW'(1);
          st_d    = ST_OK;
        end else begin
          st_d    = ST_NOT_FOUND;
        end
        state_d = S_RESP;
      end
      S_DUMP: begin
        if (out_fire) begin
          ctrl.op = OP_ROTATE;
          if (dump_last) begin
            state_d = S_IDLE;
          end else begin
            idx_d = idx_q + CountW'(1);
          end
        end
      end
      default: begin
      end
    endcase

    // new command (taken in IDLE, or as the single result beat leaves)
    if (in_fire) begin
      unique case (cmd)
        CMD_APPEND, CMD_INSERT: begin
          state_d = S_RESP;
          if ((cmd == CMD_INSERT) && (pos_ext > PosCmpW'(count_q))) begin
            st_d = ST_BAD_POS;
          end else if (count_q == CountFull) begin
            st_d = ST_FULL;
          end else begin
            ctrl.op  = OP_INSERT;
            cell_pos = (cmd == CMD_INSERT) ? CountW'(pos_ext) : count_q;
            count_d  = count_q + CountW'(1);
            st_d     = ST_OK;
          end
        end
        CMD_DELETE: begin
          if (count_q == '0) begin
            st_d    = ST_EMPTY;
            state_d = S_RESP;
          end else begin
            ctrl.op = OP_MATCH;
            state_d = S_DEL;
          end
        end
        CMD_DUMP: begin
          if (count_q == '0) begin
            st_d    = ST_EMPTY;
            state_d = S_RESP;
          end else begin
            idx_d   = '0;
            state_d = S_DUMP;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
      idx_q   <= '0;
      st_q    <= ST_OK;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      idx_q   <= idx_d;
      st_q    <= st_d;
    end
  end

  // ---- channel outputs ----
  assign s_axis_tready_o = (state_q == S_IDLE) ||
                           ((state_q == S_RESP) && m_axis_tready_i);
  assign m_axis_tvalid_o = (state_q == S_RESP) || (state_q == S_DUMP);

  // dump beats come straight from the head cell register
  assign m_axis_tdata_o[2:0]   = (state_q == S_DUMP) ? ST_OK : st_q;
  assign m_axis_tdata_o[34:3]  = (state_q == S_DUMP) ? entry[0] : '0;
  assign m_axis_tdata_o[39:35] = LengthW'(count_q);
  assign m_axis_tlast_o        = (state_q == S_DUMP) ? dump_last : 1'b1;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountFull)
    else $error("list length above capacity");

  a_dump_count_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) && $past(state_q == S_DUMP) |-> $stable(count_q))
    else $error("list length changed during dump");

  a_dump_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DUMP) && out_fire && m_axis_tlast_o |=> (state_q == S_IDLE))
    else $error("dump did not finish after last beat");

  a_del_resolves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DEL) |=> (state_q == S_RESP) &&
      ((st_q == ST_OK) || (st_q == ST_NOT_FOUND)))
    else $error("delete did not resolve to a result");
`endif

endmodule

@@ hw/rtl/ole_cell.sv @@
module ole_cell import ole_pkg::*; #(
  parameter int unsigned CountW  = 5,
  parameter int unsigned CellIdx = 0
) (
  input  logic              clk_i,
  input  ole_ctrl_t         ctrl_i,
  input  logic [CountW-1:0] pos_i,
  input  logic [CountW-1:0] count_i,
  input  logic [ValueW-1:0] left_i,
  input  logic [ValueW-1:0] right_i,
  input  logic [ValueW-1:0] head_i,
  input  logic              found_i,
  output logic [ValueW-1:0] entry_o,
  output logic              found_o
);

  localparam logic [CountW-1:0] Idx     = CountW'(CellIdx);
  localparam logic [CountW-1:0] IdxNext = CountW'(CellIdx + 1);

  logic [ValueW-1:0] entry_q, entry_d;
  logic              match_q, match_d;

  // first-match chain: everything at or after the first hit moves up
  assign found_o = found_i | match_q;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    match_d = match_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (Idx == pos_i) begin
          entry_d = ctrl_i.value;
        end else if (Idx > pos_i) begin
          entry_d = left_i;
        end
      end
      OP_MATCH: begin
        match_d = (entry_q == ctrl_i.value) && (Idx < count_i);
      end
      OP_REMOVE: begin
        if (found_o) begin
          entry_d = right_i;
        end
      end
      OP_ROTATE: begin
        // tail of the live list wraps the head around
        entry_d = (IdxNext == count_i) ? head_i : right_i;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
    match_q <= match_d;
  end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import ole_pkg::*;

  localparam int unsigned LIST_DEPTH  = DefCapacity;
  localparam int unsigned RANDOM_CMDS = 430;
  localparam int unsigned STALL_LIMIT = 1000;
  localparam int unsigned MAX_REPORTS = 10;

  // one result beat as the block reports it
  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ValueW-1:0]  entry;
    logic [LengthW-1:0] len;
    logic               last;
  } list_beat_t;

  // directed row: reps > 1 appends val, val+1, val+2, val, ... ;
  // typed rows carry their one expected beat (entry 0, last 1)
  typedef struct packed {
    logic [1:0]           cmd;
    logic [PositionW-1:0] pos;
    logic [ValueW-1:0]    val;
    logic [4:0]           reps;
    logic                 typed;
    logic [StatusW-1:0]   st;
    logic [LengthW-1:0]   len;
  } plan_row_t;

  localparam int unsigned PLAN_ROWS = 19;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{CMD_DUMP,   5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,     5'd0},
    '{CMD_DELETE, 5'd0,  32'h0000_0000, 5'd1,  1'b1, ST_EMPTY,     5'd0},
    '{CMD_INSERT, 5'd1,  32'h1111_1111, 5'd1,  1'b1, ST_BAD_POS,   5'd0},
    '{CMD_INSERT, 5'd0,  32'h8000_0000, 5'd1,  1'b1, ST_OK,        5'd1},
    '{CMD_APPEND, 5'd31, 32'h7FFF_FFFF, 5'd1,  1'b1, ST_OK,        5'd2},
    '{CMD_INSERT, 5'd31, 32'hFFFF_FFFF, 5'd1,  1'b1, ST_BAD_POS,   5'd2},
    '{CMD_INSERT, 5'd2,  32'h0000_0000, 5'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_INSERT, 5'd1,  32'h5555_5555, 5'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_DELETE, 5'd0,  32'h1234_5678, 5'd1,  1'b1, ST_NOT_FOUND, 5'd4},
    '{CMD_DUMP,   5'd0,  32'h0000_0000, 5'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_APPEND, 5'd0,  32'h0000_0001, 5'd12, 1'b0, ST_OK,        5'd0},
    '{CMD_APPEND, 5'd0,  32'hFFFF_FFFF, 5'd1,  1'b1, ST_FULL,      5'd16},
    '{CMD_INSERT, 5'd16, 32'hAAAA_AAAA, 5'd1,  1'b1, ST_FULL,      5'd16},
    '{CMD_INSERT, 5'd17, 32'hAAAA_AAAA, 5'd1,  1'b1, ST_BAD_POS,   5'd16},
    '{CMD_DUMP,   5'd0,  32'h0000_0000, 5'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_DELETE, 5'd0,  32'h8000_0000, 5'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_DELETE, 5'd0,  32'h0000_0002, 5'd1,  1'b0, ST_OK,        5'd0},
    '{CMD_DELETE, 5'd0,  32'hFFFF_FFFF, 5'd1,  1'b1, ST_NOT_FOUND, 5'd14},
    '{CMD_DUMP,   5'd0,  32'h0000_0000, 5'd1,  1'b0, ST_OK,        5'd0}
  };

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_valid = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_data = '0;
  logic        m_axis_tvalid_o;
  logic        rx_ready = 1'b0;
  logic [39:0] m_axis_tdata_o;
  logic        m_axis_tlast_o;

  // shadow copy of the list
  logic [ValueW-1:0] shadow_list [LIST_DEPTH];
  int unsigned       shadow_len = 0;

  list_beat_t fresh_beats[$];  // beats caused by the latest command
  list_beat_t due_beats[$];    // beats still owed by the block

  int unsigned mismatches = 0;
  int unsigned quiet_cycles = 0;
  int unsigned rx_wait = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  ordered_list_engine #(
    .CAPACITY(LIST_DEPTH)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_axis_tready_o),
    // [1:0] command, [6:2] position, [38:7] value, [39] zero fill
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(rx_ready),
    // [2:0] status, [34:3] entry_value, [39:35] length
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // per-beat idle draw; calm stretches run with no idling at all
  function automatic int unsigned draw_pause(inout bit calm);
    if ($urandom_range(0, 29) == 0) calm = !calm;
    return calm ? 0 : $urandom_range(0, 17);
  endfunction

  // values: clusters of small numbers give duplicates, plus the extremes
  function automatic logic [ValueW-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 30) return ValueW'($signed($urandom_range(0, 7)) - 4);
    if (r < 40) begin
      case ($urandom_range(0, 3))
        0:       return 32'h8000_0000;
        1:       return 32'h7FFF_FFFF;
        2:       return 32'h0000_0000;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return $urandom;
  endfunction

  // apply one command to the shadow list, leave its beats in fresh_beats
  function automatic void model_command(input logic [1:0] cmd,
                                        input logic [PositionW-1:0] pos,
                                        input logic [ValueW-1:0] val);
    logic [StatusW-1:0] st;
    int unsigned        slot;
    int                 hit;
    fresh_beats.delete();
    st = ST_OK;
    case (cmd)
      CMD_APPEND, CMD_INSERT: begin
        slot = (cmd == CMD_APPEND) ? shadow_len : 32'(pos);
        if (slot > shadow_len) st = ST_BAD_POS;
        else if (shadow_len >= LIST_DEPTH) st = ST_FULL;
        else begin
          for (int i = shadow_len; i > slot; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[slot] = val;
          shadow_len++;
        end
      end
      CMD_DELETE: begin
        hit = -1;
        for (int i = 0; i < shadow_len; i++)
          if (hit < 0 && shadow_list[i] == val) hit = i;
        if (shadow_len == 0) st = ST_EMPTY;
        else if (hit < 0) st = ST_NOT_FOUND;
        else begin
          for (int i = hit; i + 1 < shadow_len; i++) shadow_list[i] = shadow_list[i+1];
          shadow_len--;
        end
      end
      default: begin
        if (shadow_len == 0) st = ST_EMPTY;
        for (int i = 0; i < shadow_len; i++)
          fresh_beats.push_back('{ST_OK, shadow_list[i], LengthW'(shadow_len),
                                  (i + 1 == shadow_len)});
      end
    endcase
    if (fresh_beats.size() == 0)
      fresh_beats.push_back('{st, '0, LengthW'(shadow_len), 1'b1});
  endfunction

  // one command beat: idle gap, hold until taken, then book its results
  task automatic issue_command(input logic [1:0] cmd, input logic [PositionW-1:0] pos,
                               input logic [ValueW-1:0] val, input bit use_typed,
                               input list_beat_t typed_beat);
    int unsigned gap;
    gap = draw_pause(tx_calm);
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_valid <= 1'b1;
    s_data  <= {1'b0, val, pos, cmd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    model_command(cmd, pos, val);
    if (use_typed) due_beats.push_back(typed_beat);
    else foreach (fresh_beats[i]) due_beats.push_back(fresh_beats[i]);
  endtask

  // result side: random stalls, every taken beat checked against the oldest due
  always @(posedge clk_i) begin
    list_beat_t got;
    list_beat_t want;
    if (!rst_ni) begin
      rx_ready <= 1'b0;
    end else begin
      if (m_axis_tvalid_o && rx_ready) begin
        got = '{m_axis_tdata_o[2:0], m_axis_tdata_o[34:3], m_axis_tdata_o[39:35],
                m_axis_tlast_o};
        if (due_beats.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: result beat with nothing due: st=%0d val=%h len=%0d last=%b",
                     $realtime, got.status, got.entry, got.len, got.last);
        end else begin
          want = due_beats.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("%0t: result mismatch: st %0d/%0d val %h/%h len %0d/%0d last %b/%b",
                       $realtime, got.status, want.status, got.entry, want.entry,
                       got.len, want.len, got.last, want.last);
          end
        end
        rx_wait = draw_pause(rx_calm);
      end else if (rx_wait > 0) begin
        rx_wait--;
      end
      rx_ready <= (rx_wait == 0);
    end
  end

  // watchdog: too long with no beat on either side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_valid && s_axis_tready_o) || (m_axis_tvalid_o && rx_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    plan_row_t         row;
    list_beat_t        typed_beat;
    logic [1:0]        cmd;
    logic [PositionW-1:0] pos;
    logic [ValueW-1:0] val;
    bit                grow;
    int unsigned       r;

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part: empty list, extremes, bad positions, full list, head delete
    for (int n = 0; n < PLAN_ROWS; n++) begin
      row = PLAN[n];
      typed_beat = '{row.st, '0, row.len, 1'b1};
      for (int k = 0; k < row.reps; k++)
        issue_command(row.cmd, row.pos, row.val + ValueW'(k % 3), row.typed, typed_beat);
    end

    // random part: grow and shrink phases so the list sweeps empty to full
    grow = 1'b1;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      if (n == RANDOM_CMDS / 2) begin
        // hold the sender off until the block has drained
        s_valid <= 1'b0;
        while (due_beats.size() != 0) @(posedge clk_i);
      end
      if ($urandom_range(0, 24) == 0) grow = !grow;
      r   = $urandom_range(0, 99);
      pos = PositionW'($urandom_range(0, 31));
      val = pick_value();
      if (r < 10) begin
        cmd = CMD_DUMP;
      end else if (r < (grow ? 50 : 25)) begin
        cmd = CMD_APPEND;
      end else if (r < (grow ? 85 : 40)) begin
        cmd = CMD_INSERT;
        if ($urandom_range(0, 9) != 0 || shadow_len >= 31)
          pos = PositionW'($urandom_range(0, shadow_len));
        else
          pos = PositionW'($urandom_range(shadow_len + 1, 31));
      end else begin
        cmd = CMD_DELETE;
        if (shadow_len > 0 && $urandom_range(0, 3) != 0)
          val = shadow_list[$urandom_range(0, shadow_len - 1)];
      end
      issue_command(cmd, pos, val, 1'b0, '0);
    end
    s_valid <= 1'b0;

    while (due_beats.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    if (mismatches == 0 && due_beats.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/ole_pkg.sv
hw/rtl/ole_cell.sv
hw/rtl/ordered_list_engine.sv
test/testbench.sv
